### src/apes_pkg.sv
// shared types, constants and arithmetic helpers for the affine pair scan
package apes_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int PAIR_W       = 64;

  localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] Q_ZERO = 32'sh0000_0000;

  // write data select codes
  localparam logic [1:0] WSEL_INPUT = 2'd0;
  localparam logic [1:0] WSEL_IDENT = 2'd1;
  localparam logic [1:0] WSEL_COMB  = 2'd2;
  localparam logic [1:0] WSEL_RREG  = 2'd3;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [1:0]        wsel;
    logic [ADDR_W-1:0] raddr;
    logic              lat_l;
    logic              lat_r;
    logic              mul_a;
    logic              mul_b;
    logic              down;
    logic              out_load;
    logic              out_last;
  } cmd_t;

  // smallest power of two not below n
  function automatic logic [CNT_W-1:0] padded_size(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] m;
    m = CNT_W'(1);
    for (int i = 0; i < ADDR_W; i++) begin
      if (m < n) begin
        m = m << 1;
      end
    end
    return m;
  endfunction

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'sh0_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -49'sh0_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### src/apes_ram.sv
// generic single write port, single read port ram with registered read
module apes_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/apes_dp.sv
// datapath: pair store, combine unit and result register
module apes_dp
  import apes_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic signed [31:0] mult_in,
  input  logic signed [31:0] offset_in,
  output logic               valid,
  output logic signed [31:0] mult_out,
  output logic signed [31:0] offset_out,
  output logic               last_out
);

  logic [PAIR_W-1:0]  wdata;
  logic [PAIR_W-1:0]  rdata;
  logic [PAIR_W-1:0]  reg_l;
  logic [PAIR_W-1:0]  reg_r;
  logic signed [31:0] ra, rb, la, lb;
  logic signed [63:0] prod;
  logic signed [31:0] a_res;
  logic signed [31:0] b_res;
  logic signed [48:0] b_sum;

  apes_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_ELEMENTS)) u_store (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (cmd.waddr),
    .wdata (wdata),
    .raddr (cmd.raddr),
    .rdata (rdata)
  );

  // up-sweep: r is the right node; down-sweep: r is the old left node
  always_comb begin
    if (cmd.down) begin
      ra = reg_l[63:32];
      rb = reg_l[31:0];
      la = reg_r[63:32];
      lb = reg_r[31:0];
    end else begin
      ra = reg_r[63:32];
      rb = reg_r[31:0];
      la = reg_l[63:32];
      lb = reg_l[31:0];
    end
  end

  // floored product plus offset, saturated once
  assign b_sum = $signed({prod[63], prod[63:16]}) + 49'(rb);
  assign b_res = sat32(b_sum);

  always_comb begin
    case (cmd.wsel)
      WSEL_INPUT: wdata = {mult_in, offset_in};
      WSEL_IDENT: wdata = {Q_ONE, Q_ZERO};
      WSEL_COMB:  wdata = {a_res, b_res};
      WSEL_RREG:  wdata = reg_r;
      default:    wdata = reg_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.lat_l) begin
      reg_l <= rdata;
    end
    if (cmd.lat_r) begin
      reg_r <= rdata;
    end
    if (cmd.mul_a) begin
      prod <= ra * la;
    end
    if (cmd.mul_b) begin
      a_res <= sat32($signed({prod[63], prod[63:16]}));
      prod  <= ra * lb;
    end
    if (cmd.out_load) begin
      mult_out   <= rdata[63:32];
      offset_out <= rdata[31:0];
      last_out   <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.out_load;
    end
  end

endmodule

### src/apes_ctrl.sv
// controller: collection, padding, up-sweep, down-sweep and emission sequencing
module apes_ctrl
  import apes_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic last_in,
  output logic busy,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PAD    = 4'd1;
  localparam logic [3:0] S_CLR    = 4'd2;
  localparam logic [3:0] S_RD_L   = 4'd3;
  localparam logic [3:0] S_RD_R   = 4'd4;
  localparam logic [3:0] S_LAT_R  = 4'd5;
  localparam logic [3:0] S_MUL_A  = 4'd6;
  localparam logic [3:0] S_MUL_B  = 4'd7;
  localparam logic [3:0] S_WR_I   = 4'd8;
  localparam logic [3:0] S_WR_L   = 4'd9;
  localparam logic [3:0] S_EM_RD  = 4'd10;
  localparam logic [3:0] S_EM_OUT = 4'd11;

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] n, n_next;
  logic [CNT_W-1:0] m, m_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W:0]   stride, stride_next;
  logic             down, down_next;

  logic [CNT_W-1:0] left;
  logic [CNT_W:0]   idx_step;
  logic [CNT_W:0]   stride_up;
  logic [CNT_W:0]   stride_dn;

  assign left      = idx - stride[CNT_W:1];
  assign idx_step  = {1'b0, idx} + stride;
  assign stride_up = stride << 1;
  assign stride_dn = stride >> 1;
  assign busy      = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    count_next  = count;
    n_next      = n;
    m_next      = m;
    idx_next    = idx;
    stride_next = stride;
    down_next   = down;

    cmd          = '0;
    cmd.down     = down;
    cmd.waddr    = idx[ADDR_W-1:0];
    cmd.raddr    = idx[ADDR_W-1:0];
    cmd.wsel     = WSEL_IDENT;
    cmd.out_last = (idx == n - CNT_W'(1));

    unique case (state) inside
      S_IDLE: begin
        if (start) begin
          cmd.we    = 1'b1;
          cmd.waddr = count[ADDR_W-1:0];
          cmd.wsel  = WSEL_INPUT;
          if (last_in || count == CNT_W'(MAX_ELEMENTS - 1)) begin
            n_next     = count + CNT_W'(1);
            m_next     = padded_size(count + CNT_W'(1));
            idx_next   = count + CNT_W'(1);
            count_next = '0;
            state_next = S_PAD;
          end else begin
            count_next = count + CNT_W'(1);
          end
        end
      end
      S_PAD: begin
        if (idx == m) begin
          down_next = 1'b0;
          if (m >= CNT_W'(2)) begin
            stride_next = (CNT_W+1)'(2);
            idx_next    = CNT_W'(1);
            state_next  = S_RD_L;
          end else begin
            state_next = S_CLR;
          end
        end else begin
          cmd.we    = 1'b1;
          cmd.wsel  = WSEL_IDENT;
          idx_next  = idx + CNT_W'(1);
        end
      end
      S_CLR: begin
        cmd.we    = 1'b1;
        cmd.waddr = ADDR_W'(m - CNT_W'(1));
        cmd.wsel  = WSEL_IDENT;
        down_next = 1'b1;
        if (m >= CNT_W'(2)) begin
          stride_next = {1'b0, m};
          idx_next    = m - CNT_W'(1);
          state_next  = S_RD_L;
        end else begin
          idx_next   = '0;
          state_next = S_EM_RD;
        end
      end
      S_RD_L: begin
        cmd.raddr  = left[ADDR_W-1:0];
        state_next = S_RD_R;
      end
      S_RD_R: begin
        cmd.lat_l  = 1'b1;
        state_next = S_LAT_R;
      end
      S_LAT_R: begin
        cmd.lat_r  = 1'b1;
        state_next = S_MUL_A;
      end
      S_MUL_A: begin
        cmd.mul_a  = 1'b1;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_b  = 1'b1;
        state_next = S_WR_I;
      end
      S_WR_I, S_WR_L: begin
        cmd.we = 1'b1;
        if (state == S_WR_I) begin
          cmd.wsel = WSEL_COMB;
        end else begin
          cmd.waddr = left[ADDR_W-1:0];
          cmd.wsel  = WSEL_RREG;
        end
        if (state == S_WR_I && down) begin
          state_next = S_WR_L;
        end else if (idx_step < {1'b0, m}) begin
          idx_next   = idx_step[CNT_W-1:0];
          state_next = S_RD_L;
        end else if (!down) begin
          if (stride_up > {1'b0, m}) begin
            state_next = S_CLR;
          end else begin
            stride_next = stride_up;
            idx_next    = stride_up[CNT_W-1:0] - CNT_W'(1);
            state_next  = S_RD_L;
          end
        end else begin
          if (stride_dn < (CNT_W+1)'(2)) begin
            idx_next   = '0;
            state_next = S_EM_RD;
          end else begin
            stride_next = stride_dn;
            idx_next    = stride_dn[CNT_W-1:0] - CNT_W'(1);
            state_next  = S_RD_L;
          end
        end
      end
      S_EM_RD: begin
        state_next = S_EM_OUT;
      end
      S_EM_OUT: begin
        cmd.out_load = 1'b1;
        if (idx == n - CNT_W'(1)) begin
          state_next = S_IDLE;
        end else begin
          idx_next   = idx + CNT_W'(1);
          state_next = S_EM_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      down  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      down  <= down_next;
    end
  end

  always_ff @(posedge clk) begin
    n      <= n_next;
    m      <= m_next;
    idx    <= idx_next;
    stride <= stride_next;
  end

endmodule

### src/affine_pair_exclusive_scan_top.sv
// top level of the affine pair exclusive prefix scan
// sequence: after the closing transfer the store is padded to m; each up-sweep combine reads
//   both nodes, latches them, forms two products in turn and writes; then a clear step and
//   down-sweep combines that also move the old right node left (m-1 of each, m = pow2 >= n)
// throughput: one input transfer per cycle while collecting; busy from the close until the
//   last result; the 32x32 products, formed in turn, and the one store read port set the pace
// reset: synchronous active high rst empties the set and idles; the store is not cleared
module affine_pair_exclusive_scan_top
  import apes_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input transfer: start high while busy low
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] mult_in,
  input  logic signed [31:0] offset_in,
  input  logic               last_in,
  // result transfer: valid high for exactly one cycle per result
  output logic               valid,
  output logic signed [31:0] mult_out,
  output logic signed [31:0] offset_out,
  output logic               last_out
);

  // command bundle from the sequencer to the datapath
  cmd_t cmd;

  // sequencer: collects the set, pads to a power of two, walks both sweeps
  apes_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .last_in (last_in),
    .busy    (busy),
    .cmd     (cmd)
  );

  // datapath: pair store, saturating q16.16 combine, result register
  apes_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .mult_in    (mult_in),
    .offset_in  (offset_in),
    .valid      (valid),
    .mult_out   (mult_out),
    .offset_out (offset_out),
    .last_out   (last_out)
  );

endmodule
